// ----- hw/rtl/tmwf_pkg.sv -----
// Shared types and constants for the trimmed-mean window filter.
// No dependencies; imported by the filter top level.
`timescale 1ns / 1ps

package tmwf_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int LEN_W             = 8;
    localparam int DATA_W            = 32;
    localparam int ADDR_W            = 3;
    localparam int WINDOW_DEPTH_DEF  = 256;
    localparam int MIN_LEN           = 3;
    localparam int TRIM_COUNT        = 2;
    localparam logic [LEN_W-1:0] LEN_RESET = 8'd20;

    // Register index, taken from paddr[2].
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_TRIM_LO,
        ST_TRIM_HI,
        ST_ABS,
        ST_DIV,
        ST_FIX
    } t_state;

endpackage

// ----- hw/rtl/tmwf_ram.sv -----
// Generic simple dual-port RAM with registered read data.
// No dependencies; used for the filter sample window.
`timescale 1ns / 1ps

module tmwf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/trimmed_mean_window_filter_top.sv -----
// Top level of the trimmed-mean (olympic) moving-average filter.
// Depends on tmwf_pkg and instantiates tmwf_ram for the sample window.
`timescale 1ns / 1ps

// Each request carries one signed 16-bit current sample. The sample is stored
// in a ring window at the current write position, then the first L entries of
// the window are read back one per cycle from a single RAM read port while one
// shared adder accumulates the sum and two comparators track the minimum and
// maximum. One minimum and one maximum are subtracted, and the remainder is
// divided by L-2 with a restoring divider that reuses the same adder, one
// quotient bit per cycle, truncating toward zero. The input is stalled through
// the RAM scan and the serial divide, from the acceptance of a request until
// its result is written; the finished result sits in an output register, so
// the next request is taken while it waits. L is the window_length register
// (address 0) clamped to 3..WINDOW_DEPTH; writing it restarts the write
// position at entry 0. After reset every window entry reads as zero through
// per-entry valid flops, so no clearing pass is needed and early results
// include those zeros.
module trimmed_mean_window_filter_top
    #(
    parameter int WINDOW_DEPTH = tmwf_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Sample requests in.
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [tmwf_pkg::SAMPLE_W-1:0] i_current_sample,
    // Filtered results out.
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [tmwf_pkg::SAMPLE_W-1:0] o_filtered_current,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tmwf_pkg::ADDR_W-1:0]          paddr,
    input  logic [tmwf_pkg::DATA_W-1:0]          pwdata,
    output logic [tmwf_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);

    import tmwf_pkg::*;

    // AW addresses the window, CNT_W holds a length up to the depth itself.
    localparam int AW     = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int LW     = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    // Sum of up to WINDOW_DEPTH signed samples, plus one bit of headroom in
    // the shared adder.
    localparam int SUM_W  = SAMPLE_W + AW + 1;
    localparam int ALU_W  = SUM_W + 1;
    localparam int STEP_W = $clog2(SUM_W);

    t_state r_state, n_state;

    logic [LEN_W-1:0]           r_len;
    logic [AW-1:0]              r_pos, n_pos;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [WINDOW_DEPTH-1:0]    r_valid;
    logic [CNT_W-1:0]           r_idx, n_idx;
    logic                       r_rd_vld, n_rd_vld;
    logic                       r_rd_hit;
    logic                       r_first, n_first;
    logic signed [SUM_W-1:0]    r_sum, n_sum;
    logic signed [SAMPLE_W-1:0] r_lo, n_lo;
    logic signed [SAMPLE_W-1:0] r_hi, n_hi;
    logic                       r_neg, n_neg;
    logic [SUM_W-1:0]           r_q, n_q;
    logic [CNT_W-1:0]           r_rem, n_rem;
    logic [STEP_W-1:0]          r_step, n_step;
    logic                       r_out_valid, n_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_data, n_out_data;

    logic                       cfg_wr;
    logic                       in_take;
    logic [LW-1:0]              len_ext;
    logic [LW-1:0]              len_clamp;
    logic [CNT_W-1:0]           win_len;
    logic [CNT_W-1:0]           divisor;
    logic [AW-1:0]              wr_addr;
    logic [CNT_W-1:0]           pos_inc;
    logic                       ram_we;
    logic signed [SAMPLE_W-1:0] ram_q;
    logic signed [SAMPLE_W-1:0] scan_val;
    logic [CNT_W:0]             rem_sh;

    // The one shared adder/subtractor.
    logic signed [ALU_W-1:0]    alu_a;
    logic signed [ALU_W-1:0]    alu_b;
    logic                       alu_sub;
    logic signed [ALU_W-1:0]    alu_y;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_LENGTH);
    assign prdata  = (paddr[2] == REG_WINDOW_LENGTH) ? {{(DATA_W-LEN_W){1'b0}}, r_len}
                                                     : '0;

    assign o_stall = (r_state != ST_IDLE);
    assign in_take = i_valid && !o_stall;

    // Effective window length, clamped to 3..WINDOW_DEPTH.
    assign len_ext   = {{(LW-LEN_W){1'b0}}, r_len};
    assign len_clamp = (len_ext < LW'(MIN_LEN))      ? LW'(MIN_LEN) :
                       (len_ext > LW'(WINDOW_DEPTH)) ? LW'(WINDOW_DEPTH) : len_ext;
    assign win_len   = len_clamp[CNT_W-1:0];
    assign divisor   = win_len - CNT_W'(TRIM_COUNT);

    // A position left beyond the window restarts at entry 0.
    assign wr_addr = ({{(CNT_W-AW){1'b0}}, r_pos} >= win_len) ? '0 : r_pos;
    assign pos_inc = {{(CNT_W-AW){1'b0}}, wr_addr} + CNT_W'(1);
    assign ram_we  = (r_state == ST_WRITE);

    tmwf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_addr),
        .i_wdata (r_sample),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_q)
    );

    // Entries never written since reset read as zero.
    assign scan_val = r_rd_hit ? ram_q : '0;
    assign rem_sh   = {r_rem, r_q[SUM_W-1]};
    assign alu_y    = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_rd_vld    = 1'b0;
        n_first     = r_first;
        n_sum       = r_sum;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_neg       = r_neg;
        n_q         = r_q;
        n_rem       = r_rem;
        n_step      = r_step;
        n_out_valid = r_out_valid && i_stall;
        n_out_data  = r_out_data;
        alu_a       = '0;
        alu_b       = '0;
        alu_sub     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                n_pos   = (pos_inc >= win_len) ? '0 : pos_inc[AW-1:0];
                n_idx   = '0;
                n_first = 1'b1;
                n_sum   = '0;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                // Reads are issued one per cycle; data lands in the next cycle.
                if (r_idx < win_len) begin
                    n_idx    = r_idx + CNT_W'(1);
                    n_rd_vld = 1'b1;
                end
                if (r_rd_vld) begin
                    alu_a   = {{(ALU_W-SUM_W){r_sum[SUM_W-1]}}, r_sum};
                    alu_b   = {{(ALU_W-SAMPLE_W){scan_val[SAMPLE_W-1]}}, scan_val};
                    n_sum   = alu_y[SUM_W-1:0];
                    n_first = 1'b0;
                    if (r_first || (scan_val < r_lo)) begin
                        n_lo = scan_val;
                    end
                    if (r_first || (scan_val > r_hi)) begin
                        n_hi = scan_val;
                    end
                    if (r_idx == win_len) begin
                        n_state = ST_TRIM_LO;
                    end
                end
            end
            ST_TRIM_LO: begin
                alu_a   = {{(ALU_W-SUM_W){r_sum[SUM_W-1]}}, r_sum};
                alu_b   = {{(ALU_W-SAMPLE_W){r_lo[SAMPLE_W-1]}}, r_lo};
                alu_sub = 1'b1;
                n_sum   = alu_y[SUM_W-1:0];
                n_state = ST_TRIM_HI;
            end
            ST_TRIM_HI: begin
                alu_a   = {{(ALU_W-SUM_W){r_sum[SUM_W-1]}}, r_sum};
                alu_b   = {{(ALU_W-SAMPLE_W){r_hi[SAMPLE_W-1]}}, r_hi};
                alu_sub = 1'b1;
                n_sum   = alu_y[SUM_W-1:0];
                n_state = ST_ABS;
            end
            ST_ABS: begin
                // Divide the magnitude; the sign is put back at the end so
                // that the quotient truncates toward zero.
                alu_b   = {{(ALU_W-SUM_W){r_sum[SUM_W-1]}}, r_sum};
                alu_sub = 1'b1;
                n_neg   = r_sum[SUM_W-1];
                n_q     = r_sum[SUM_W-1] ? alu_y[SUM_W-1:0] : r_sum;
                n_rem   = '0;
                n_step  = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                alu_a   = {{(ALU_W-CNT_W-1){1'b0}}, rem_sh};
                alu_b   = {{(ALU_W-CNT_W){1'b0}}, divisor};
                alu_sub = 1'b1;
                if (!alu_y[ALU_W-1]) begin
                    n_rem = alu_y[CNT_W-1:0];
                    n_q   = {r_q[SUM_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[CNT_W-1:0];
                    n_q   = {r_q[SUM_W-2:0], 1'b0};
                end
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                alu_a   = r_neg ? '0 : {1'b0, r_q};
                alu_b   = r_neg ? {1'b0, r_q} : '0;
                alu_sub = r_neg;
                // Wait here only while the previous result is still unread.
                if (!(r_out_valid && i_stall)) begin
                    n_out_valid = 1'b1;
                    n_out_data  = alu_y[SAMPLE_W-1:0];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Length write restarts ring; user writes only while idle, unchecked.
        if (cfg_wr) begin
            n_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= LEN_RESET;
            r_pos       <= '0;
            r_valid     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_len <= pwdata[LEN_W-1:0];
            end
            r_pos       <= n_pos;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
            if (ram_we) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_sample <= i_current_sample;
        end
        r_rd_hit   <= r_valid[r_idx[AW-1:0]];
        r_idx      <= n_idx;
        r_first    <= n_first;
        r_sum      <= n_sum;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_neg      <= n_neg;
        r_q        <= n_q;
        r_rem      <= n_rem;
        r_step     <= n_step;
        r_out_data <= n_out_data;
    end

    assign o_valid            = r_out_valid;
    assign o_filtered_current = r_out_data;

endmodule
